// File: sv/egcd_pkg.sv
// Package for the extended GCD coefficient core: payload structs, microcode
// control word layout and the microcode program ROM.
// No dependencies.
`default_nettype none

package egcd_pkg;

    localparam int OPERAND_W      = 31;
    localparam int COEF_W         = 32;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CNT_W          = $clog2(OPERAND_W);
    localparam int STEP_W         = 3;

    typedef struct packed {
        logic [OPERAND_W-1:0] operand_a;
        logic [OPERAND_W-1:0] operand_b;
    } egcd_in_t;

    typedef struct packed {
        logic [OPERAND_W-1:0]     gcd_value;
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic                     status;
    } egcd_out_t;

    // Datapath operation of one microcode step
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_UPDATE,
        OP_RESULT,
        OP_ZERO
    } op_t;

    // Sequencing condition of one microcode step
    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_WAIT_IN,
        C_RC_ZERO,
        C_LOOP,
        C_REM_NZ,
        C_WAIT_OUT
    } cond_t;

    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucode_t;

    localparam step_t ST_WAIT     = 3'd0;
    localparam step_t ST_CHECK    = 3'd1;
    localparam step_t ST_DIV_INIT = 3'd2;
    localparam step_t ST_DIV_STEP = 3'd3;
    localparam step_t ST_UPDATE   = 3'd4;
    localparam step_t ST_RESULT   = 3'd5;
    localparam step_t ST_ZERO     = 3'd6;
    localparam step_t ST_SPARE    = 3'd7;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t cw;
        unique case (step)
            ST_WAIT:     cw = '{op: OP_LOAD,     cond: C_WAIT_IN,  target: ST_CHECK};
            ST_CHECK:    cw = '{op: OP_NOP,      cond: C_RC_ZERO,  target: ST_ZERO};
            ST_DIV_INIT: cw = '{op: OP_DIV_INIT, cond: C_NEXT,     target: ST_DIV_STEP};
            ST_DIV_STEP: cw = '{op: OP_DIV_STEP, cond: C_LOOP,     target: ST_UPDATE};
            ST_UPDATE:   cw = '{op: OP_UPDATE,   cond: C_REM_NZ,   target: ST_DIV_INIT};
            ST_RESULT:   cw = '{op: OP_RESULT,   cond: C_WAIT_OUT, target: ST_WAIT};
            ST_ZERO:     cw = '{op: OP_ZERO,     cond: C_WAIT_OUT, target: ST_WAIT};
            ST_SPARE:    cw = '{op: OP_NOP,      cond: C_JUMP,     target: ST_WAIT};
            default:     cw = '{op: OP_NOP,      cond: C_JUMP,     target: ST_WAIT};
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

// File: sv/extended_gcd_coefficients_core.sv
// Top level of the extended GCD coefficient core: microcode sequencer,
// bit-serial divider and coefficient accumulators.
// Depends on egcd_pkg.
`default_nettype none

// Computes gcd(a,b) and Bezout coefficients coef_a, coef_b with
// coef_a*a + coef_b*b = gcd. A zero operand_b gives status 1 and zero fields.
// One transaction is processed at a time. Each Euclid step is an init step,
// a restoring division (one quotient bit per cycle) that also accumulates
// quotient*coefficient bit-serially, and an update step.
// An operation needs N Euclid steps, N at most 46 for 31-bit operands.
// A finished result sits in the output register while the next transaction
// is taken in.
module extended_gcd_coefficients_core #(
    parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEF
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  egcd_pkg::egcd_in_t    s_data,
    output logic                  m_valid,
    input  wire                   m_ready,
    output egcd_pkg::egcd_out_t   m_data
);

    import egcd_pkg::*;

    typedef logic signed [DATA_WIDTH-1:0] coef_t;

    step_t                step_reg, step_next;
    ucode_t               cw;
    logic                 adv;
    logic                 m_valid_reg, m_valid_next;
    egcd_out_t            out_reg, out_next;

    logic [OPERAND_W-1:0] rp_reg, rp_next;     // previous remainder
    logic [OPERAND_W-1:0] rc_reg, rc_next;     // current remainder (divisor)
    logic [OPERAND_W-1:0] dvd_reg, dvd_next;   // dividend bits, MSB first
    logic [OPERAND_W-1:0] part_reg, part_next; // partial remainder
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    coef_t                cap_reg, cap_next, cac_reg, cac_next;
    coef_t                cbp_reg, cbp_next, cbc_reg, cbc_next;
    coef_t                pa_reg, pa_next, pb_reg, pb_next;

    logic [OPERAND_W:0]   trial;
    logic [OPERAND_W:0]   diff;
    logic                 qbit;

    assign cw = ucode_rom(step_reg);

    // Sequencer
    always_comb begin
        step_next = step_reg;
        adv       = 1'b1;
        unique case (cw.cond)
            C_NEXT:     step_next = step_reg + step_t'(1);
            C_JUMP:     step_next = cw.target;
            C_WAIT_IN: begin
                if (s_valid) begin
                    step_next = cw.target;
                end else begin
                    adv = 1'b0;
                end
            end
            C_RC_ZERO:  step_next = (rc_reg == '0) ? cw.target : step_reg + step_t'(1);
            C_LOOP:     step_next = (cnt_reg != '0) ? step_reg : step_reg + step_t'(1);
            C_REM_NZ:   step_next = (part_reg != '0) ? cw.target : step_reg + step_t'(1);
            C_WAIT_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    step_next = cw.target;
                end else begin
                    adv = 1'b0;
                end
            end
            default:    step_next = ST_WAIT;
        endcase
    end

    // Restoring division step
    assign trial = {part_reg, dvd_reg[OPERAND_W-1]};
    assign diff  = trial - {1'b0, rc_reg};
    assign qbit  = (trial >= {1'b0, rc_reg});

    // Datapath
    always_comb begin
        rp_next      = rp_reg;
        rc_next      = rc_reg;
        dvd_next     = dvd_reg;
        part_next    = part_reg;
        cnt_next     = cnt_reg;
        cap_next     = cap_reg;
        cac_next     = cac_reg;
        cbp_next     = cbp_reg;
        cbc_next     = cbc_reg;
        pa_next      = pa_reg;
        pb_next      = pb_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        if (adv) begin
            case (cw.op)
                OP_LOAD: begin
                    rp_next  = s_data.operand_a;
                    rc_next  = s_data.operand_b;
                    cap_next = coef_t'(1);
                    cac_next = '0;
                    cbp_next = '0;
                    cbc_next = coef_t'(1);
                end
                OP_DIV_INIT: begin
                    dvd_next  = rp_reg;
                    part_next = '0;
                    cnt_next  = CNT_W'(OPERAND_W - 1);
                    pa_next   = '0;
                    pb_next   = '0;
                end
                OP_DIV_STEP: begin
                    part_next = qbit ? diff[OPERAND_W-1:0] : trial[OPERAND_W-1:0];
                    dvd_next  = {dvd_reg[OPERAND_W-2:0], 1'b0};
                    cnt_next  = cnt_reg - CNT_W'(1);
                    // Accumulate quotient times coefficient, MSB first
                    pa_next   = (pa_reg <<< 1) + (qbit ? cac_reg : coef_t'(0));
                    pb_next   = (pb_reg <<< 1) + (qbit ? cbc_reg : coef_t'(0));
                end
                OP_UPDATE: begin
                    rp_next  = rc_reg;
                    rc_next  = part_reg;
                    cap_next = cac_reg;
                    cac_next = cap_reg - pa_reg;
                    cbp_next = cbc_reg;
                    cbc_next = cbp_reg - pb_reg;
                end
                OP_RESULT: begin
                    // Remainder hit zero: the previous row holds the gcd
                    out_next.gcd_value = rp_reg;
                    out_next.coef_a    = COEF_W'(cap_reg);
                    out_next.coef_b    = COEF_W'(cbp_reg);
                    out_next.status    = 1'b0;
                    m_valid_next       = 1'b1;
                end
                OP_ZERO: begin
                    out_next     = '{gcd_value: '0, coef_a: '0, coef_b: '0, status: 1'b1};
                    m_valid_next = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= ST_WAIT;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rp_reg   <= rp_next;
        rc_reg   <= rc_next;
        dvd_reg  <= dvd_next;
        part_reg <= part_next;
        cnt_reg  <= cnt_next;
        cap_reg  <= cap_next;
        cac_reg  <= cac_next;
        cbp_reg  <= cbp_next;
        cbc_reg  <= cbc_next;
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        out_reg  <= out_next;
    end

    assign s_ready = (cw.op == OP_LOAD);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire
